// File: hw/rtl/lbb_pkg.sv
package lbb_pkg;

  localparam int unsigned KeyW   = 18;
  localparam int unsigned SizeW  = 35;
  localparam int unsigned StampW = 64;
  localparam int unsigned CntW   = 64;

  localparam logic CmdAccess = 1'b0;
  localparam logic CmdProbe  = 1'b1;

  localparam logic [0:0] RegByteBudget = 1'b0;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanLast,
    StDecide,
    StEvict,
    StStore,
    StOut
  } lbb_state_e;

  // one slot record as kept in the slot memory
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [SizeW-1:0]  size;
    logic [StampW-1:0] stamp;
  } lbb_entry_t;

  // result word of one item
  typedef struct packed {
    logic [CntW-1:0]  evictions_total;
    logic [CntW-1:0]  misses_total;
    logic [CntW-1:0]  hits_total;
    logic [SizeW-1:0] bytes_used;
    logic [8:0]       entry_count;
    logic [8:0]       evicted_now;
    logic [7:0]       slot;
    logic             bypassed;
    logic             stored;
    logic             hit;
  } lbb_result_t;

endpackage

// File: hw/rtl/lbb_slot_mem.sv
module lbb_slot_mem
  import lbb_pkg::*;
#(
  parameter int unsigned Slots = 256,
  parameter int unsigned IdxW  = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  lbb_entry_t       wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output lbb_entry_t       rdata_o
);

  lbb_entry_t mem_q [Slots];
  lbb_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lru_byte_budget_cache_policy_unit.sv
// LRU cache policy with a byte budget, keyed by (layer, expert). Slot keys,
// sizes and use stamps live in one single-port-read memory; valid bits are
// flip-flops. Each item sweeps the memory one slot per cycle to find its key,
// the first free slot and the oldest entry. A miss that stores needs one
// further sweep per evicted entry. A bypassed miss costs as much as a hit.
// One item is in flight at a time; the result sits in an output register
// and the next word is accepted once it is taken.
module lru_byte_budget_cache_policy_unit
  import lbb_pkg::*;
#(
  parameter int unsigned Slots = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: layer[9:0], expert[17:10], entry_bytes[52:18], zero pad [55:53]
  input  logic [55:0]  s_axis_tdata,
  // tuser: cmd
  input  logic         s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: hit[0], stored[1], bypassed[2], slot[10:3], evicted_now[19:11],
  // entry_count[28:20], bytes_used[63:29], hits_total[127:64],
  // misses_total[191:128], evictions_total[255:192]
  output logic [255:0] m_axis_tdata
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntSW = $clog2(Slots + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  lbb_state_e state_q, state_d;

  logic [SizeW-1:0]  budget_q;
  logic              cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [SizeW-1:0]  size_q;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [IdxW-1:0]   rptr_q;
  logic              scan_q;
  logic              found_q, found_d;
  logic [IdxW-1:0]   fidx_q, fidx_d;
  logic [SizeW-1:0]  fsize_q, fsize_d;
  logic              free_q, free_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic              old_q, old_d;
  logic [IdxW-1:0]   old_idx_q, old_idx_d;
  logic [StampW-1:0] old_stamp_q, old_stamp_d;
  logic [SizeW-1:0]  old_size_q, old_size_d;
  logic [Slots-1:0]  valid_q, valid_d;
  logic [CntSW-1:0]  count_q, count_d;
  logic [StampW-1:0] clock_q, clock_d;
  logic [SizeW-1:0]  bytes_q, bytes_d;
  logic [CntW-1:0]   hits_q, hits_d, misses_q, misses_d, evs_q, evs_d;
  logic [8:0]        evnow_q, evnow_d;
  lbb_result_t       res_q, res_d;
  logic              out_valid_q, out_valid_d;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  lbb_entry_t        mem_wdata, mem_rdata;
  logic [SizeW:0]    need;
  logic              accept;
  logic              rv;

  lbb_slot_mem #(.Slots(Slots), .IdxW(IdxW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  // config: 64-bit data because the budget is 35 bits
  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegByteBudget) ? {29'd0, budget_q} : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == RegByteBudget)) begin
      budget_q <= pwdata[SizeW-1:0];
    end
  end

  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {res_q.evictions_total, res_q.misses_total, res_q.hits_total,
                         res_q.bytes_used, res_q.entry_count, res_q.evicted_now,
                         res_q.slot, res_q.bypassed, res_q.stored, res_q.hit};

  assign need = {1'b0, bytes_q} + {1'b0, size_q};
  assign rv = valid_q[rptr_q];

  // sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fsize_d     = fsize_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    old_d       = old_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    old_size_d  = old_size_q;
    valid_d     = valid_q;
    count_d     = count_q;
    clock_d     = clock_q;
    bytes_d     = bytes_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    evs_d       = evs_q;
    evnow_d     = evnow_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = fidx_q;
    mem_wdata   = '{key: key_q, size: size_q, stamp: clock_q};

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ptr_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          old_d   = 1'b0;
          evnow_d = '0;
          state_d = StScan;
        end
      end
      StScan, StScanLast: begin
        // fold in the word read for rptr_q once a sweep read is in the pipe
        if (scan_q) begin
          if (rv) begin
            if (mem_rdata.key == key_q && !found_q) begin
              found_d = 1'b1;
              fidx_d  = rptr_q;
              fsize_d = mem_rdata.size;
            end
            if (!old_q || mem_rdata.stamp < old_stamp_q) begin
              old_d       = 1'b1;
              old_idx_d   = rptr_q;
              old_stamp_d = mem_rdata.stamp;
              old_size_d  = mem_rdata.size;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = rptr_q;
          end
        end
        if (state_q == StScanLast) begin
          state_d = StDecide;
        end else if (ptr_q == LastIdx) begin
          state_d = StScanLast;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      StDecide: begin
        res_d.hit = 1'b0; res_d.stored = 1'b0; res_d.bypassed = 1'b0;
        res_d.slot = '0;
        state_d = StOut;
        if (cmd_q == CmdProbe) begin
          res_d.hit = found_q;
          if (found_q) res_d.slot = 8'(fidx_q);
        end else if (evnow_q == '0 && found_q) begin
          clock_d = clock_q + 1'b1;
          hits_d  = hits_q + 1'b1;
          mem_we  = 1'b1;
          mem_waddr = fidx_q;
          mem_wdata = '{key: key_q, size: fsize_q, stamp: clock_q + 1'b1};
          res_d.hit  = 1'b1;
          res_d.slot = 8'(fidx_q);
        end else if (evnow_q == '0 && (budget_q == '0 || size_q > budget_q)) begin
          clock_d  = clock_q + 1'b1;
          misses_d = misses_q + 1'b1;
          res_d.bypassed = 1'b1;
        end else begin
          if (evnow_q == '0) begin
            clock_d  = clock_q + 1'b1;
            misses_d = misses_q + 1'b1;
          end
          if ((need > {1'b0, budget_q} || !free_q) && old_q) begin
            state_d = StEvict;
          end else begin
            state_d = StStore;
          end
        end
      end
      StEvict: begin
        valid_d[old_idx_q] = 1'b0;
        count_d = count_q - 1'b1;
        bytes_d = bytes_q - old_size_q;
        evs_d   = evs_q + 1'b1;
        evnow_d = evnow_q + 1'b1;
        // rescan for the next victim and free slot
        ptr_d   = '0;
        free_d  = 1'b0;
        old_d   = 1'b0;
        state_d = StScan;
      end
      StStore: begin
        valid_d[free_idx_q] = 1'b1;
        count_d = count_q + 1'b1;
        bytes_d = bytes_q + size_q;
        mem_we  = 1'b1;
        mem_waddr = free_idx_q;
        mem_wdata = '{key: key_q, size: size_q, stamp: clock_q};
        res_d.stored = 1'b1;
        res_d.slot   = 8'(free_idx_q);
        state_d = StOut;
      end
      StOut: begin
        res_d.evicted_now     = evnow_q;
        res_d.entry_count     = 9'(count_q);
        res_d.bytes_used      = bytes_q;
        res_d.hits_total      = hits_q;
        res_d.misses_total    = misses_q;
        res_d.evictions_total = evs_q;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      clock_q     <= '0;
      bytes_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= (state_q == StScan);
      valid_q     <= valid_d;
      count_q     <= count_d;
      clock_q     <= clock_d;
      bytes_q     <= bytes_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evs_q       <= evs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      key_q  <= {s_axis_tdata[9:0], s_axis_tdata[17:10]};
      size_q <= s_axis_tdata[52:18];
    end
    ptr_q       <= ptr_d;
    rptr_q      <= ptr_q;
    found_q     <= found_d;
    fidx_q      <= fidx_d;
    fsize_q     <= fsize_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    old_q       <= old_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    old_size_q  <= old_size_d;
    evnow_q     <= evnow_d;
    res_q       <= res_d;
  end

  logic unused_ok;
  assign unused_ok = ^pwdata[63:SizeW];

endmodule

// File: tb/lbb_policy_checker.sv
module lbb_policy_checker
  import lbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // tdata: layer, expert, entry_bytes, pad
  input  logic [55:0]  s_axis_tdata,
  // tuser: cmd
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: hit, stored, bypassed, slot, evicted_now, entry_count, bytes_used,
  // hits_total, misses_total, evictions_total
  input  logic [255:0] m_axis_tdata,
  output int unsigned  mismatch_count,
  output int unsigned  pending_count
);

  localparam int NumSlots = 256;
  localparam int unsigned QDepth = 64;

  // shadow copy of the cache table
  logic              slot_used [NumSlots];
  logic [KeyW-1:0]   slot_tag [NumSlots];
  logic [StampW-1:0] slot_stamp [NumSlots];
  logic [SizeW-1:0]  slot_bytes [NumSlots];
  logic [StampW-1:0] use_tick;
  logic [SizeW-1:0]  cached_bytes;
  logic [SizeW-1:0]  budget;
  logic [CntW-1:0]   hit_cnt;
  logic [CntW-1:0]   miss_cnt;
  logic [CntW-1:0]   evict_cnt;
  int                live_entries;

  // predicted words waiting for their result
  lbb_result_t pred_buf [QDepth];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;

  assign pending_count = wr_ptr - rd_ptr;

  // drop the least recently used entry, lowest index on ties
  task automatic drop_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_used[i] && (victim < 0 || slot_stamp[i] < slot_stamp[victim])) victim = i;
    end
    if (victim >= 0) begin
      cached_bytes = cached_bytes - slot_bytes[victim];
      slot_used[victim] = 1'b0;
      live_entries--;
      evict_cnt++;
    end
  endtask

  // apply one lookup or probe to the shadow table and form its result
  task automatic lookup_and_place(input logic cmd, input logic [KeyW-1:0] tag,
                                  input logic [SizeW-1:0] bytes, output lbb_result_t r);
    int idx;
    logic [CntW-1:0] evict_start;
    idx = -1;
    evict_start = evict_cnt;
    r = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (idx < 0 && slot_used[i] && slot_tag[i] == tag) idx = i;
    end
    if (cmd == CmdProbe) begin
      if (idx >= 0) begin
        r.hit = 1'b1;
        r.slot = idx[7:0];
      end
    end else begin
      use_tick++;
      if (idx >= 0) begin
        slot_stamp[idx] = use_tick;
        hit_cnt++;
        r.hit = 1'b1;
        r.slot = idx[7:0];
      end else begin
        miss_cnt++;
        if (budget == '0 || bytes > budget) begin
          r.bypassed = 1'b1;
        end else begin
          while ({1'b0, cached_bytes} + {1'b0, bytes} > {1'b0, budget} && live_entries > 0)
            drop_oldest();
          if (live_entries >= NumSlots) drop_oldest();
          for (int i = 0; i < NumSlots; i++) begin
            if (!r.stored && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_tag[i] = tag;
              slot_bytes[i] = bytes;
              slot_stamp[i] = use_tick;
              cached_bytes = cached_bytes + bytes;
              live_entries++;
              r.stored = 1'b1;
              r.slot = i[7:0];
            end
          end
        end
      end
    end
    r.evicted_now = 9'(evict_cnt - evict_start);
    r.entry_count = 9'(live_entries);
    r.bytes_used = cached_bytes;
    r.hits_total = hit_cnt;
    r.misses_total = miss_cnt;
    r.evictions_total = evict_cnt;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // track register writes, predict on each accepted word, compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    lbb_result_t want;
    lbb_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) slot_used[i] = 1'b0;
      use_tick = '0;
      cached_bytes = '0;
      budget = '0;
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      live_entries = 0;
      mismatch_count = 0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[3] == RegByteBudget) begin
        budget = pwdata[SizeW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_and_place(s_axis_tuser, {s_axis_tdata[9:0], s_axis_tdata[17:10]},
                         s_axis_tdata[52:18], want);
        pred_buf[wr_ptr % QDepth] = want;
        wr_ptr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (wr_ptr == rd_ptr) begin
          mismatch_count++;
          $display("%0t: unexpected result word %0h", $time, m_axis_tdata);
        end else begin
          want = pred_buf[rd_ptr % QDepth];
          rd_ptr++;
          check_field("hit", 64'(want.hit), 64'(got.hit));
          check_field("stored", 64'(want.stored), 64'(got.stored));
          check_field("bypassed", 64'(want.bypassed), 64'(got.bypassed));
          check_field("slot", 64'(want.slot), 64'(got.slot));
          check_field("evicted_now", 64'(want.evicted_now), 64'(got.evicted_now));
          check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
          check_field("bytes_used", 64'(want.bytes_used), 64'(got.bytes_used));
          check_field("hits_total", want.hits_total, got.hits_total);
          check_field("misses_total", want.misses_total, got.misses_total);
          check_field("evictions_total", want.evictions_total, got.evictions_total);
        end
      end
    end
  end

endmodule

// File: tb/tb_lru_byte_budget_cache_policy_unit.sv
module tb_lru_byte_budget_cache_policy_unit;
  import lbb_pkg::*;

  localparam int unsigned StallLimit = 300000;
  localparam logic [34:0] BudgetMax = 35'h7FFFFFFFF;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: layer[9:0], expert[17:10], entry_bytes[52:18], zero pad [55:53]
  logic [55:0]  s_axis_tdata = '0;
  // tuser: cmd
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: hit, stored, bypassed, slot, evicted_now, entry_count, bytes_used,
  // hits_total, misses_total, evictions_total
  logic [255:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  lru_byte_budget_cache_policy_unit dut (.*);

  lbb_policy_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatch_count, .pending_count
  );

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static logic hold_done = 1'b0;
    if (rx_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_lru_byte_budget_cache_policy_unit: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [9:0] layer,
                           input logic [7:0] expert, input logic [34:0] bytes);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b000, bytes, expert, layer};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_budget(input logic [34:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'd0;
    pwdata <= {29'd0, value};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly keys from a small pool so hits and restamps are common
  task automatic random_traffic(input int count, input int unsigned size_max);
    logic       cmd;
    logic [9:0] layer;
    logic [7:0] expert;
    logic [34:0] bytes;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < 20) ? CmdProbe : CmdAccess;
      if ($urandom_range(9) == 0) begin
        layer = 10'($urandom_range(1023));
        expert = 8'($urandom_range(255));
      end else begin
        layer = 10'($urandom_range(3));
        expert = 8'($urandom_range(15));
      end
      case ($urandom_range(19))
        0: bytes = '0;
        1: bytes = 35'({$urandom, $urandom});
        default: bytes = 35'($urandom_range(size_max, 1));
      endcase
      send_word(cmd, layer, expert, bytes);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // budget zero: miss bypasses, probe of an empty table
    tx_idle_pct = 35;
    rx_idle_pct = 64;
    send_word(CmdAccess, 10'd0, 8'd0, 35'd5);
    send_word(CmdProbe, 10'd0, 8'd0, 35'd5);
    wait_drained();

    // small budget: zero size, exact fit, too large, hit, probe, eviction
    write_budget(35'd1000);
    send_word(CmdAccess, 10'd1023, 8'd255, 35'd0);
    send_word(CmdAccess, 10'd0, 8'd0, 35'd1000);
    send_word(CmdAccess, 10'd5, 8'd5, 35'd1001);
    send_word(CmdAccess, 10'd1023, 8'd255, 35'd7);
    send_word(CmdProbe, 10'd1023, 8'd255, 35'd0);
    send_word(CmdAccess, 10'd1, 8'd1, 35'd600);
    wait_drained();

    // largest budget with extreme sizes
    write_budget(BudgetMax);
    send_word(CmdAccess, 10'h2AA, 8'hAA, BudgetMax);
    send_word(CmdAccess, 10'h155, 8'h55, 35'h555555555);
    send_word(CmdAccess, 10'h2AA, 8'hAA, 35'h2AAAAAAAA);
    send_word(CmdProbe, 10'h2AA, 8'hAA, 35'd0);
    send_word(CmdProbe, 10'h155, 8'h55, BudgetMax);
    wait_drained();

    write_budget(35'h400000000);
    send_word(CmdAccess, 10'd9, 8'd9, 35'h400000001);
    send_word(CmdAccess, 10'd9, 8'd9, 35'h400000000);
    wait_drained();

    // fill every slot, then keep missing so the full table evicts
    write_budget(BudgetMax);
    for (int i = 0; i < 264; i++) begin
      send_word(CmdAccess, 10'(900 + (i >> 8)), 8'(i), 35'($urandom_range(1000, 1)));
    end
    random_traffic(100, 1000);

    // sender pauses until every result is back, then the budget drops
    wait_drained();
    write_budget(35'd5000);
    random_traffic(80, 2000);
    wait_drained();

    // swap idle rates; receiver holds off long while words keep coming
    tx_idle_pct = 64;
    rx_idle_pct = 35;
    write_budget(35'd3000);
    rx_hold_req <= 1'b1;
    random_traffic(120, 1500);
    wait_drained();

    // no idling at all
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_budget(35'd0);
    random_traffic(10, 100);
    wait_drained();
    write_budget(35'd20000);
    random_traffic(60, 6000);
    wait_drained();

    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_lru_byte_budget_cache_policy_unit: done, clean");
    end else begin
      $display("tb_lru_byte_budget_cache_policy_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: lru_byte_budget_cache_policy_unit.f
hw/rtl/lbb_pkg.sv
hw/rtl/lbb_slot_mem.sv
hw/rtl/lru_byte_budget_cache_policy_unit.sv
tb/lbb_policy_checker.sv
tb/tb_lru_byte_budget_cache_policy_unit.sv
